// File: rtl/mer_pkg.sv
`default_nettype none

package mer_pkg;

  // fixed field widths
  localparam int AXIS_W      = 5;
  localparam int COLOR_W     = 32;
  // squares and products of the semi-axes
  localparam int SQ_W        = 2 * AXIS_W;
  localparam int PR_W        = 3 * AXIS_W;
  // running offsets and decision terms
  localparam int STEP_W      = 7;
  localparam int DEC_W       = 24;
  // word limit per command and its counter width
  localparam int MAX_RESULTS = 46;
  localparam int CNT_W       = 6;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture a command word
    logic square;   // a*a and b*b
    logic product;  // a*a*b and b*b*a
    logic init;     // region one start values, region two decision term
    logic step;     // emit one word and advance
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;    // output register can take a word
    logic final_word;  // word about to be emitted closes the command
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/midpoint_ellipse_raster_top.sv
// Midpoint ellipse outline rasterizer.
// Input channel (in_valid/in_ready): one word per ellipse: center column and
// row, horizontal and vertical semi-axes (clamped to MAX_AXIS) and a color.
// Output channel (out_valid/out_ready): one word per midpoint step, holding
// the four symmetric points center +/- (x, y) and the color; out_last marks
// the final word of an ellipse. A command gives 1 to 46 words.
// The first word passes through the squares, products, start values and
// output register after the command is accepted.
// One output word per cycle while tracing, unless the receiver stalls; the
// rate is set by the single add-only step unit that keeps b*b*x and a*a*y
// as running sums.
// in_ready is high only while no ellipse is being traced; the next command
// may be accepted while the last word still waits in the output register.
// A stalled receiver holds the output register and freezes the walk; no word
// is lost or repeated.
// Reset (rst_n, synchronous, active low) returns the controller to idle and
// empties the output register.
`default_nettype none

module midpoint_ellipse_raster_top #(
  parameter int MAX_AXIS   = 31,
  parameter int COORD_BITS = 11
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [COORD_BITS-1:0]          in_center_x,
  input  wire logic [COORD_BITS-1:0]          in_center_y,
  input  wire logic [mer_pkg::AXIS_W-1:0]     in_semi_axis_x,
  input  wire logic [mer_pkg::AXIS_W-1:0]     in_semi_axis_y,
  input  wire logic [mer_pkg::COLOR_W-1:0]    in_pixel_color,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [COORD_BITS+1:0]        out_right_x,
  output logic signed [COORD_BITS+1:0]        out_left_x,
  output logic signed [COORD_BITS+1:0]        out_lower_y,
  output logic signed [COORD_BITS+1:0]        out_upper_y,
  output logic [mer_pkg::COLOR_W-1:0]         out_color,
  output logic                                out_last
);

  mer_pkg::cmd_t  cmd;
  mer_pkg::stat_t stat;

  // sequencer
  mer_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic and output register
  mer_datapath #(
    .COORD_BITS (COORD_BITS),
    .MAX_AXIS   (MAX_AXIS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_semi_axis_x (in_semi_axis_x),
    .in_semi_axis_y (in_semi_axis_y),
    .in_pixel_color (in_pixel_color),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_right_x    (out_right_x),
    .out_left_x     (out_left_x),
    .out_lower_y    (out_lower_y),
    .out_upper_y    (out_upper_y),
    .out_color      (out_color),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

// File: rtl/mer_ctrl.sv
`default_nettype none

module mer_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mer_pkg::stat_t stat,
  output mer_pkg::cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQR  = 3'd1;
  localparam logic [2:0] ST_PROD = 3'd2;
  localparam logic [2:0] ST_INIT = 3'd3;
  localparam logic [2:0] ST_RUN  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // command decode and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        cmd.square = 1'b1;
        state_nxt  = ST_PROD;
      end
      ST_PROD: begin
        cmd.product = 1'b1;
        state_nxt   = ST_INIT;
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (stat.out_free) begin
          cmd.step = 1'b1;
          if (stat.final_word) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_step_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> stat.out_free)
    else $error("step issued with output register full");

  a_load_to_square: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_SQR))
    else $error("load not followed by square");

  a_final_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && stat.final_word) |=> (state_r == ST_IDLE))
    else $error("final word did not end the command");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command");
`endif

endmodule

`default_nettype wire

// File: rtl/mer_datapath.sv
`default_nettype none

module mer_datapath #(
  parameter int COORD_BITS = 11,
  parameter int MAX_AXIS   = 31
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire mer_pkg::cmd_t                       cmd,
  output mer_pkg::stat_t                           stat,
  input  wire logic [COORD_BITS-1:0]               in_center_x,
  input  wire logic [COORD_BITS-1:0]               in_center_y,
  input  wire logic [mer_pkg::AXIS_W-1:0]          in_semi_axis_x,
  input  wire logic [mer_pkg::AXIS_W-1:0]          in_semi_axis_y,
  input  wire logic [mer_pkg::COLOR_W-1:0]         in_pixel_color,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [COORD_BITS+1:0]             out_right_x,
  output logic signed [COORD_BITS+1:0]             out_left_x,
  output logic signed [COORD_BITS+1:0]             out_lower_y,
  output logic signed [COORD_BITS+1:0]             out_upper_y,
  output logic [mer_pkg::COLOR_W-1:0]              out_color,
  output logic                                     out_last
);

  localparam int OUT_W  = COORD_BITS + 2;
  localparam int AW     = mer_pkg::AXIS_W;
  localparam int SW     = mer_pkg::STEP_W;
  localparam int DW     = mer_pkg::DEC_W;
  localparam int QW     = mer_pkg::SQ_W;
  localparam int PW     = mer_pkg::PR_W;
  localparam int CW     = mer_pkg::CNT_W;
  localparam int AXIS_P = AW + 1;

  // command word
  logic [COORD_BITS-1:0]     cx_r, cy_r;
  logic [AW-1:0]             a_r, b_r;
  logic [mer_pkg::COLOR_W-1:0] color_r;
  // squares and products
  logic [QW-1:0]             a2_r, b2_r;
  logic [PW-1:0]             pa_r, qb_r;
  logic signed [DW-1:0]      d2i_r;
  // walk state: p = b*b*x, q = a*a*y
  logic signed [SW-1:0]      x_r, y_r;
  logic signed [DW-1:0]      d_r, p_r, q_r;
  logic                      reg2_r;
  logic                      zero_r;
  logic [CW-1:0]             cnt_r;
  logic                      out_valid_r;

  logic [AW-1:0]             a_sat, b_sat;
  logic signed [DW-1:0]      a2e, b2e, pae, qbe;
  logic signed [SW-1:0]      x_nxt, y_nxt;
  logic signed [DW-1:0]      d_nxt, p_nxt, q_nxt;
  logic signed [DW-1:0]      d_adj;
  logic                      test_nxt;
  logic                      final_word;

  // semi-axis clamp
  assign a_sat = ({1'b0, in_semi_axis_x} > AXIS_P'(MAX_AXIS)) ? AW'(MAX_AXIS) : in_semi_axis_x;
  assign b_sat = ({1'b0, in_semi_axis_y} > AXIS_P'(MAX_AXIS)) ? AW'(MAX_AXIS) : in_semi_axis_y;

  assign a2e = $signed({{(DW-QW){1'b0}}, a2_r});
  assign b2e = $signed({{(DW-QW){1'b0}}, b2_r});
  assign pae = $signed({{(DW-PW){1'b0}}, pa_r});
  assign qbe = $signed({{(DW-PW){1'b0}}, qb_r});

  // one midpoint step, with the loop test of the following step
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    p_nxt = p_r;
    q_nxt = q_r;
    d_adj = d_r;
    if (!reg2_r) begin
      if (!d_r[DW-1]) begin
        d_adj = d_r + (a2e <<< 2) - (q_r <<< 2);
        y_nxt = y_r - SW'(1);
        q_nxt = q_r - a2e;
      end
      d_nxt    = d_adj + (p_r <<< 2) + (b2e <<< 2) + (b2e <<< 1);
      x_nxt    = x_r + SW'(1);
      p_nxt    = p_r + b2e;
      test_nxt = (p_nxt <= q_nxt);
    end else begin
      if (!d_r[DW-1]) begin
        d_adj = d_r + (b2e <<< 2) - (p_r <<< 2);
        x_nxt = x_r - SW'(1);
        p_nxt = p_r - b2e;
      end
      d_nxt    = d_adj + (q_r <<< 2) + (a2e <<< 2) + (a2e <<< 1);
      y_nxt    = y_r + SW'(1);
      q_nxt    = q_r + a2e;
      test_nxt = (q_nxt <= p_nxt);
    end
  end

  // a region one exit hands over to region two, which emits at least once unless the word limit is reached
  assign final_word = zero_r || (cnt_r == CW'(mer_pkg::MAX_RESULTS - 1)) ||
                      (reg2_r && !test_nxt);

  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.final_word = final_word;

  // command capture and setup arithmetic
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r    <= in_center_x;
      cy_r    <= in_center_y;
      a_r     <= a_sat;
      b_r     <= b_sat;
      color_r <= in_pixel_color;
    end
    if (cmd.square) begin
      a2_r <= QW'(a_r * a_r);
      b2_r <= QW'(b_r * b_r);
    end
    if (cmd.product) begin
      pa_r <= PW'(b2_r * a_r);
      qb_r <= PW'(a2_r * b_r);
    end
    if (cmd.init) begin
      d2i_r <= (a2e <<< 1) + b2e - (pae <<< 1);
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      x_r    <= '0;
      y_r    <= $signed({{(SW-AW){1'b0}}, b_r});
      d_r    <= (b2e <<< 1) + a2e - (qbe <<< 1);
      p_r    <= '0;
      q_r    <= qbe;
      reg2_r <= 1'b0;
      zero_r <= (a_r == '0) && (b_r == '0);
      cnt_r  <= '0;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + CW'(1);
      if (!reg2_r && !test_nxt) begin
        x_r    <= $signed({{(SW-AW){1'b0}}, a_r});
        y_r    <= '0;
        d_r    <= d2i_r;
        p_r    <= pae;
        q_r    <= '0;
        reg2_r <= 1'b1;
      end else begin
        x_r <= x_nxt;
        y_r <= y_nxt;
        d_r <= d_nxt;
        p_r <= p_nxt;
        q_r <= q_nxt;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_right_x <= $signed({2'b00, cx_r}) + OUT_W'(x_r);
      out_left_x  <= $signed({2'b00, cx_r}) - OUT_W'(x_r);
      out_lower_y <= $signed({2'b00, cy_r}) + OUT_W'(y_r);
      out_upper_y <= $signed({2'b00, cy_r}) - OUT_W'(y_r);
      out_color   <= color_r;
      out_last    <= final_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: bench/testbench.sv
`default_nettype none

module testbench;

  localparam int MAX_AXIS   = 31;
  localparam int COORD_BITS = 11;
  localparam int OUT_W      = COORD_BITS + 2;
  localparam int MAX_WORDS  = mer_pkg::MAX_RESULTS;
  localparam int N_RANDOM   = 440;
  localparam int HOLD_AT    = 120;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_WAIT = 60;
  localparam int CYCLE_MAX  = 500000;

  // receiver ready patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_HALF,
    RX_ONE_IN_FOUR,
    RX_MOSTLY
  } rx_mode_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]       cx;
    logic [COORD_BITS-1:0]       cy;
    logic [mer_pkg::AXIS_W-1:0]  ax;
    logic [mer_pkg::AXIS_W-1:0]  ay;
    logic [mer_pkg::COLOR_W-1:0] color;
  } ellipse_t;

  typedef struct packed {
    logic [OUT_W-1:0]            right_x;
    logic [OUT_W-1:0]            left_x;
    logic [OUT_W-1:0]            lower_y;
    logic [OUT_W-1:0]            upper_y;
    logic [mer_pkg::COLOR_W-1:0] color;
    logic                        last;
  } quad_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [COORD_BITS-1:0]       in_center_x = '0;
  logic [COORD_BITS-1:0]       in_center_y = '0;
  logic [mer_pkg::AXIS_W-1:0]  in_semi_axis_x = '0;
  logic [mer_pkg::AXIS_W-1:0]  in_semi_axis_y = '0;
  logic [mer_pkg::COLOR_W-1:0] in_pixel_color = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [OUT_W-1:0]     out_right_x;
  logic signed [OUT_W-1:0]     out_left_x;
  logic signed [OUT_W-1:0]     out_lower_y;
  logic signed [OUT_W-1:0]     out_upper_y;
  logic [mer_pkg::COLOR_W-1:0] out_color;
  logic                        out_last;

  ellipse_t pending_cmds[$];
  quad_t    expected_quads[$];

  int n_directed = 0;
  int cmds_accepted = 0;
  int zero_axis_cmds = 0;
  int capped_cmds = 0;
  int quads_checked = 0;
  int fail_count = 0;
  int cycle_count = 0;

  // sender burst state
  int burst_left = 0;
  int gap_left = 0;

  // receiver state
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_cycle = 0;
  logic     rx_hold = 1'b0;
  logic     hold_done = 1'b0;
  int       hold_left = 0;
  int       hold_input_stalls = 0;

  midpoint_ellipse_raster_top #(
    .MAX_AXIS  (MAX_AXIS),
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_center_x   (in_center_x),
    .in_center_y   (in_center_y),
    .in_semi_axis_x(in_semi_axis_x),
    .in_semi_axis_y(in_semi_axis_y),
    .in_pixel_color(in_pixel_color),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_right_x   (out_right_x),
    .out_left_x    (out_left_x),
    .out_lower_y   (out_lower_y),
    .out_upper_y   (out_upper_y),
    .out_color     (out_color),
    .out_last      (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // one expected quad around the center at offset (x, y)
  function automatic void push_quad(input int cx, input int cy, input int x, input int y,
                                    input logic [mer_pkg::COLOR_W-1:0] color);
    quad_t q;
    int    s;
    s = cx + x;
    q.right_x = s[OUT_W-1:0];
    s = cx - x;
    q.left_x = s[OUT_W-1:0];
    s = cy + y;
    q.lower_y = s[OUT_W-1:0];
    s = cy - y;
    q.upper_y = s[OUT_W-1:0];
    q.color = color;
    q.last = 1'b0;
    expected_quads.push_back(q);
  endfunction

  // two-region midpoint walk, one quad per loop pass
  function automatic void trace_ellipse(input ellipse_t c);
    int    cx, cy, a, b, a2, b2, x, y, d, n;
    quad_t q;
    cx = c.cx;
    cy = c.cy;
    a = c.ax;
    b = c.ay;
    if (a > MAX_AXIS) a = MAX_AXIS;
    if (b > MAX_AXIS) b = MAX_AXIS;
    a2 = a * a;
    b2 = b * b;
    n = 0;
    if (a == 0 || b == 0) zero_axis_cmds++;
    if (a == 0 && b == 0) begin
      // degenerate: a single quad at the center
      push_quad(cx, cy, 0, 0, c.color);
      n = 1;
    end else begin
      // region one: step x, y follows
      x = 0;
      y = b;
      d = 2 * b2 + a2 * (1 - 2 * b);
      while (n < MAX_WORDS && b2 * x <= a2 * y) begin
        push_quad(cx, cy, x, y, c.color);
        n++;
        if (d >= 0) begin
          d += 4 * a2 * (1 - y);
          y--;
        end
        d += b2 * (4 * x + 6);
        x++;
      end
      // region two: step y, x follows
      x = a;
      y = 0;
      d = 2 * a2 + b2 * (1 - 2 * a);
      while (n < MAX_WORDS && a2 * y <= b2 * x) begin
        push_quad(cx, cy, x, y, c.color);
        n++;
        if (d >= 0) begin
          d += 4 * b2 * (1 - x);
          x--;
        end
        d += a2 * (4 * y + 6);
        y++;
      end
    end
    if (n == MAX_WORDS) capped_cmds++;
    q = expected_quads.pop_back();
    q.last = 1'b1;
    expected_quads.push_back(q);
  endfunction

  task automatic add_cmd(input int cx, input int cy, input int ax, input int ay,
                         input logic [mer_pkg::COLOR_W-1:0] color);
    ellipse_t c;
    c.cx = cx[COORD_BITS-1:0];
    c.cy = cy[COORD_BITS-1:0];
    c.ax = ax[mer_pkg::AXIS_W-1:0];
    c.ay = ay[mer_pkg::AXIS_W-1:0];
    c.color = color;
    pending_cmds.push_back(c);
  endtask

  function automatic int pick_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 0;
    if (sel == 1) return (1 << COORD_BITS) - 1;
    if (sel == 2) return $urandom_range(0, 40);
    return $urandom_range(0, (1 << COORD_BITS) - 1);
  endfunction

  function automatic int pick_axis();
    if ($urandom_range(0, 9) == 0) return 0;
    return $urandom_range(0, MAX_AXIS);
  endfunction

  // sender: bursts of words from the pending queue with random gaps
  always @(posedge clk) begin
    ellipse_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        c.cx = in_center_x;
        c.cy = in_center_y;
        c.ax = in_semi_axis_x;
        c.ay = in_semi_axis_y;
        c.color = in_pixel_color;
        trace_ellipse(c);
        cmds_accepted <= cmds_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          c = pending_cmds.pop_front();
          in_center_x <= c.cx;
          in_center_y <= c.cy;
          in_semi_axis_x <= c.ax;
          in_semi_axis_y <= c.ay;
          in_pixel_color <= c.color;
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off once the run is under way
  always @(posedge clk) begin
    if (rx_hold) begin
      if (in_valid && !in_ready) hold_input_stalls <= hold_input_stalls + 1;
      if (hold_left == 0) rx_hold <= 1'b0;
      else hold_left <= hold_left - 1;
    end else if (!hold_done && cmds_accepted >= HOLD_AT) begin
      rx_hold <= 1'b1;
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // receiver: ready pattern chosen at random from rx_mode_t, forced low during the hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      if (rx_hold) begin
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:        out_ready <= 1'b1;
          RX_HALF:        out_ready <= 1'($urandom_range(0, 1));
          RX_ONE_IN_FOUR: out_ready <= (rx_cycle % 4 == 0);
          default:        out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // monitor: each accepted word against the oldest expected quad
  always @(posedge clk) begin
    quad_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got.right_x = out_right_x;
      got.left_x = out_left_x;
      got.lower_y = out_lower_y;
      got.upper_y = out_upper_y;
      got.color = out_color;
      got.last = out_last;
      if (expected_quads.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected word: x %0d/%0d y %0d/%0d color %h last %b",
                   $signed(got.right_x), $signed(got.left_x), $signed(got.lower_y),
                   $signed(got.upper_y), got.color, got.last);
      end else begin
        want = expected_quads.pop_front();
        quads_checked++;
        if (got.right_x !== want.right_x || got.left_x !== want.left_x ||
            got.lower_y !== want.lower_y || got.upper_y !== want.upper_y ||
            got.color !== want.color || got.last !== want.last) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch on word %0d (command %0d)", quads_checked, cmds_accepted);
            $display("  got      x %0d/%0d y %0d/%0d color %h last %b",
                     $signed(got.right_x), $signed(got.left_x), $signed(got.lower_y),
                     $signed(got.upper_y), got.color, got.last);
            $display("  expected x %0d/%0d y %0d/%0d color %h last %b",
                     $signed(want.right_x), $signed(want.left_x), $signed(want.lower_y),
                     $signed(want.upper_y), want.color, want.last);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_MAX) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, expected_quads.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    // directed: degenerate, one-axis, extreme axes and centers
    add_cmd(1024, 1024, 0, 0, 32'h0000_0000);
    add_cmd(0, 0, 0, 0, 32'hFFFF_FFFF);
    add_cmd(2047, 2047, 0, 0, 32'hA5A5_A5A5);
    add_cmd(100, 200, 0, 31, 32'h0000_0001);
    add_cmd(100, 200, 31, 0, 32'h8000_0000);
    add_cmd(0, 0, 0, 1, 32'h5A5A_5A5A);
    add_cmd(0, 0, 1, 0, 32'h1234_5678);
    add_cmd(0, 0, 31, 31, 32'hFFFF_FFFF);
    add_cmd(2047, 2047, 31, 31, 32'h0000_0000);
    add_cmd(2047, 0, 31, 1, 32'hDEAD_BEEF);
    add_cmd(0, 2047, 1, 31, 32'hCAFE_F00D);
    add_cmd(500, 600, 1, 1, 32'h0F0F_0F0F);
    add_cmd(500, 600, 2, 3, 32'hF0F0_F0F0);
    add_cmd(1000, 1000, 17, 9, 32'h3333_CCCC);
    add_cmd(1234, 321, 31, 30, 32'h7FFF_FFFF);
    add_cmd(5, 5, 16, 16, 32'h0000_FFFF);
    add_cmd(2047, 2047, 0, 31, 32'hFFFF_0000);
    add_cmd(0, 0, 31, 0, 32'h00FF_00FF);
    add_cmd(30, 2040, 31, 2, 32'h1111_1111);
    add_cmd(2040, 30, 2, 31, 32'hEEEE_EEEE);
    n_directed = pending_cmds.size();
    // random commands
    for (int i = 0; i < N_RANDOM; i++)
      add_cmd(pick_coord(), pick_coord(), pick_axis(), pick_axis(), $urandom());

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // every command taken in, then every expected word seen
    while (cmds_accepted != n_directed + N_RANDOM) @(posedge clk);
    while (expected_quads.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d ellipse commands (%0d directed, %0d with a zero semi-axis, %0d capped),",
             cmds_accepted, n_directed, zero_axis_cmds, capped_cmds);
    $display("%0d words checked; receiver hold-off of %0d cycles stalled the input %0d cycles",
             quads_checked, HOLD_LEN, hold_input_stalls);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
